[rtl/hdris_pkg.sv]
package hdris_pkg;

    // Register map of the configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Frame geometry
    localparam int unsigned SIZE_W        = 13;
    localparam int unsigned COORD_W       = 12;
    localparam int unsigned SIZE_MIN      = 5;
    localparam int unsigned SIZE_MAX      = 4096;
    localparam int unsigned WIDTH_RESET   = 640;
    localparam int unsigned HEIGHT_RESET  = 480;
    localparam int unsigned BORDER        = 2;
    localparam int unsigned EMIT_ROW_MIN  = 4;
    localparam int unsigned READ_AHEAD    = 3;

    // One line store per value of row mod 4
    localparam int unsigned NUM_BANKS = 4;

    // Output field widths
    localparam int unsigned OUT_PIX_W = 16;

    // Class code bits
    localparam int unsigned CLS_LONG_BIT = 0;
    localparam int unsigned CLS_DIAG_BIT = 1;

    typedef logic [1:0] t_cls;
    typedef logic [SIZE_W-1:0] t_size;

    // Class of a pixel, indexed by {col mod 4, row mod 4}
    function automatic t_cls class_of(input logic [3:0] idx);
        t_cls cls;
        unique case (idx)
            4'd0:    cls = 2'd1;
            4'd1:    cls = 2'd2;
            4'd2:    cls = 2'd0;
            4'd3:    cls = 2'd2;
            4'd4:    cls = 2'd3;
            4'd5:    cls = 2'd0;
            4'd6:    cls = 2'd3;
            4'd7:    cls = 2'd1;
            4'd8:    cls = 2'd0;
            4'd9:    cls = 2'd2;
            4'd10:   cls = 2'd1;
            4'd11:   cls = 2'd2;
            4'd12:   cls = 2'd3;
            4'd13:   cls = 2'd1;
            4'd14:   cls = 2'd3;
            default: cls = 2'd0;
        endcase
        return cls;
    endfunction

    // Clamp a frame dimension to [SIZE_MIN, lim]
    function automatic t_size clamp_size(input t_size val, input t_size lim);
        t_size res;
        if (val < t_size'(SIZE_MIN)) begin
            res = t_size'(SIZE_MIN);
        end else if (val > lim) begin
            res = lim;
        end else begin
            res = val;
        end
        return res;
    endfunction

endpackage

[rtl/hdris_line_store.sv]
module hdris_line_store
    import hdris_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 4096,
    parameter int unsigned PB        = 16,
    parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [1:0]                      i_wr_bank,
    input  logic [AW-1:0]                   i_wr_addr,
    input  logic [PB-1:0]                   i_wr_data,
    input  logic                            i_rd_en,
    input  logic [AW-1:0]                   i_rd_addr,
    output logic [NUM_BANKS-1:0][PB-1:0]    o_rd_data
);

    // Write one bank per transaction, read the same column of every bank
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [PB-1:0] r_mem [MAX_WIDTH];
        logic [PB-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_bank == 2'(b))) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_rd_addr];
            end
        end

        assign o_rd_data[b] = r_rd;
    end

endmodule

[rtl/hdris_cell.sv]
module hdris_cell
    import hdris_pkg::*;
#(
    parameter int unsigned PB = 16
) (
    input  logic                            i_clk,
    input  logic                            i_shift,
    input  logic [NUM_BANKS-1:0][PB-1:0]    i_col,
    output logic [NUM_BANKS-1:0][PB-1:0]    o_col
);

    // One column of the window: a value from each line store
    logic [NUM_BANKS-1:0][PB-1:0] r_col;

    // Take the neighbour's column on every transaction
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

[rtl/hdr_interleave_split.sv]
// Splits a raw sensor frame with a 4x4 long/short exposure interleave into a
// long plane and a short plane.
// Input channel: one 16-bit raw pixel per transaction, raster order, on
// i_in_valid / o_in_stall. Output channel: one transaction per interior pixel
// (two or more away from every edge) on o_out_valid / i_out_stall, carrying
// its row, column, long and short values and a flag on the frame's last one.
// The pixel at (R-2, C) is decided by the input transaction at (R, C), and
// its result is presented on the clock after that transaction.
// Throughput: one pixel per clock unless the receiver stalls. The line stores
// are read one position of the raster three transactions ahead, so each
// transaction costs one write and one read of the four line stores; four
// window cells behind the read register shift once per transaction and hold
// every neighbour needed. The output register holds a result while the
// receiver stalls; the input is stalled only while that register is full
// and stalled, so no result is lost or repeated.
// Reset: frame size returns to 640 x 480 and the position to (0, 0). The line
// stores are not cleared: the first four rows of every frame fill them before
// any read is used. A width or height write restarts the frame at (0, 0).
module hdr_interleave_split
    import hdris_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // Input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [15:0]             i_pixel_value,
    // Output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [COORD_W-1:0]      o_out_row,
    output logic [COORD_W-1:0]      o_out_col,
    output logic [OUT_PIX_W-1:0]    o_long_value,
    output logic [OUT_PIX_W-1:0]    o_short_value,
    output logic                    o_last_of_frame
);

    localparam int unsigned AW       = $clog2(MAX_WIDTH);
    localparam int unsigned PB       = PIXEL_BITS;
    localparam int unsigned SW       = PB + 2;
    localparam int unsigned WLIM     = (MAX_WIDTH < SIZE_MAX) ? MAX_WIDTH : SIZE_MAX;
    localparam int unsigned NUM_CELLS = 4;

    typedef logic [NUM_BANKS-1:0][PB-1:0] t_col;

    // Pick the value of one line store out of a window column
    function automatic logic [SW-1:0] pick(input t_col col, input logic [1:0] bank);
        return SW'(col[bank]);
    endfunction

    // ---------------------------------------------------------------------
    // Configuration and raster position
    // ---------------------------------------------------------------------
    t_size               r_width;
    t_size               r_height;
    logic [COORD_W-1:0]  r_row;
    logic [COORD_W-1:0]  r_col;
    logic [COORD_W-1:0]  n_row;
    logic [COORD_W-1:0]  n_col;

    logic                accept;
    logic                cfg_hit;
    logic                col_end;
    logic                row_end;
    t_size               col_ext;
    t_size               row_ext;

    assign accept  = i_in_valid && !o_in_stall;
    assign cfg_hit = i_cfg_we && ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                  (i_cfg_index == REG_IMAGE_HEIGHT));
    assign col_ext = t_size'(r_col);
    assign row_ext = t_size'(r_row);
    assign col_end = (col_ext == (r_width - t_size'(1)));
    assign row_end = (row_ext == (r_height - t_size'(1)));

    // Store sizes already clamped, so the datapath never sees a size out of range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= t_size'(WIDTH_RESET);
            r_height <= t_size'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= clamp_size(i_cfg_data, t_size'(WLIM));
                REG_IMAGE_HEIGHT: r_height <= clamp_size(i_cfg_data, t_size'(SIZE_MAX));
                default: ;
            endcase
        end
    end

    // Advance in raster order; wrap to (0, 0) after the frame's last pixel
    always_comb begin
        n_row = r_row;
        n_col = r_col + COORD_W'(1);
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : (r_row + COORD_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg_hit) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------------------------------------------------------------
    // Line stores: write the incoming pixel, fetch three positions ahead
    // ---------------------------------------------------------------------
    logic [PB-1:0]  pix;
    t_size          ahead;
    t_size          rd_col;
    t_col           rd_data;

    assign pix    = i_pixel_value[PB-1:0];
    assign ahead  = col_ext + t_size'(READ_AHEAD);
    // Positions past the row end belong to the start of the next row
    assign rd_col = (ahead >= r_width) ? (ahead - r_width) : ahead;

    hdris_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .PB        (PB),
        .AW        (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_bank (r_row[1:0]),
        .i_wr_addr (AW'(r_col)),
        .i_wr_data (pix),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(rd_col)),
        .o_rd_data (rd_data)
    );

    // ---------------------------------------------------------------------
    // Window: cell k holds column C-2+k, the read register holds column C+2
    // ---------------------------------------------------------------------
    t_col win [NUM_CELLS+1];

    assign win[NUM_CELLS] = rd_data;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        hdris_cell #(
            .PB (PB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (accept),
            .i_col   (win[k+1]),
            .o_col   (win[k])
        );
    end

    // ---------------------------------------------------------------------
    // Interpolation for the pixel two rows up
    // ---------------------------------------------------------------------
    logic [1:0]      bank_r1;
    logic [1:0]      bank_r2;
    logic [1:0]      bank_r3;
    logic [1:0]      bank_r4;
    t_cls            cls;
    logic [SW-1:0]   nat;
    logic [SW-1:0]   sum_diag;
    logic [SW-1:0]   sum_cross;
    logic [SW-1:0]   sum;
    logic [PB-1:0]   other;
    logic [PB-1:0]   long_v;
    logic [PB-1:0]   short_v;
    logic            emit;
    logic            last;

    // Row R-4 shares its store with row R; its column C is still unwritten
    assign bank_r1 = r_row[1:0] - 2'd1;
    assign bank_r2 = r_row[1:0] - 2'd2;
    assign bank_r3 = r_row[1:0] - 2'd3;
    assign bank_r4 = r_row[1:0];

    assign cls = class_of({r_col[1:0], bank_r2});
    assign nat = pick(win[2], bank_r2);

    assign sum_diag  = pick(win[1], bank_r3) + pick(win[3], bank_r3)
                     + pick(win[1], bank_r1) + pick(win[3], bank_r1);
    assign sum_cross = pick(win[0], bank_r2) + pick(win[4], bank_r2)
                     + pick(win[2], bank_r4) + SW'(pix);
    assign sum       = cls[CLS_DIAG_BIT] ? sum_diag : sum_cross;
    assign other     = sum[SW-1:2];

    assign long_v  = cls[CLS_LONG_BIT] ? nat[PB-1:0] : other;
    assign short_v = cls[CLS_LONG_BIT] ? other : nat[PB-1:0];

    // Interior only: two or more away from every edge
    assign emit = (r_row >= COORD_W'(EMIT_ROW_MIN)) && (r_col >= COORD_W'(BORDER)) &&
                  ((col_ext + t_size'(BORDER)) < r_width);
    assign last = row_end && (col_ext == (r_width - t_size'(BORDER + 1)));

    // ---------------------------------------------------------------------
    // Output register: hold while the receiver stalls
    // ---------------------------------------------------------------------
    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_row;
    logic [COORD_W-1:0]   r_out_col;
    logic [OUT_PIX_W-1:0] r_long;
    logic [OUT_PIX_W-1:0] r_short;
    logic                 r_last;

    assign o_in_stall = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_row <= r_row - COORD_W'(BORDER);
            r_out_col <= r_col;
            r_long    <= OUT_PIX_W'(long_v);
            r_short   <= OUT_PIX_W'(short_v);
            r_last    <= last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_long_value    = r_long;
    assign o_short_value   = r_short;
    assign o_last_of_frame = r_last;

endmodule
